### hdl/periodic_oneshot_timer_table_assert.svh
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Concurrent check wrappers clocked on clock; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_ONESHOT_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_ONESHOT_TIMER_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// check that is off while reset is high
`define POTT_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check that also watches reset itself
`define POTT_CHECK_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define POTT_CHECK(lbl, prop, msg)
`define POTT_CHECK_RST(lbl, prop, msg)
`endif
`endif

### hdl/pott_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Sizes, item structs, slot record and time helpers shared by the timer table.
// ----------------------------------------------------------------------------
package pott_pkg;

   localparam int MAX_ROUTINES = 16;
   localparam int TIME_BITS    = 32;
   localparam int TAG_BITS     = 16;
   localparam int TICKS_BITS   = 32;
   localparam int OUT_IDX_BITS = 4;
   localparam int IDX_BITS     = (MAX_ROUTINES > 1) ? $clog2(MAX_ROUTINES) : 1;
   localparam int SUM_BITS     = (TIME_BITS > TICKS_BITS) ? TIME_BITS : TICKS_BITS;

   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_CREATE  = 1'b1;
   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_FIRED  = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [TAG_BITS-1:0]   routine_tag;
      logic [TICKS_BITS-1:0] delay_ticks;
      logic [TICKS_BITS-1:0] period_ticks;
   } req_item_type;

   typedef struct packed {
      logic                    result_kind;
      logic                    status;
      logic [OUT_IDX_BITS-1:0] slot_index;
      logic [TAG_BITS-1:0]     fired_tag;
      logic                    was_one_shot;
      logic                    last;
   } rsp_item_type;

   typedef struct packed {
      logic                  valid;
      logic [TAG_BITS-1:0]   tag;
      logic [TIME_BITS-1:0]  due;
      logic [TICKS_BITS-1:0] period;
   } slot_type;

   // now + ticks, wrapped to the time width
   function automatic logic [TIME_BITS-1:0] add_time(input logic [TIME_BITS-1:0] now,
                                                     input logic [TICKS_BITS-1:0] ticks);
      logic [SUM_BITS-1:0] sum;
      sum = SUM_BITS'(now) + SUM_BITS'(ticks);
      return sum[TIME_BITS-1:0];
   endfunction

   // due when now - due lands in the lower half of the time range
   function automatic logic time_due(input logic [TIME_BITS-1:0] due,
                                     input logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] diff;
      diff = now - due;
      return ~diff[TIME_BITS-1];
   endfunction

   function automatic logic [OUT_IDX_BITS-1:0] idx_to_out(input logic [IDX_BITS-1:0] idx);
      logic [IDX_BITS+OUT_IDX_BITS-1:0] wide;
      wide = {{OUT_IDX_BITS{1'b0}}, idx};
      return wide[OUT_IDX_BITS-1:0];
   endfunction

endpackage

### hdl/pott_cell.sv
// ----------------------------------------------------------------------------
// Timer table cell
// Holds one slot record, passes it on when the ring shifts, flags it due.
// ----------------------------------------------------------------------------
module pott_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            shift,
   input  pott_pkg::slot_type              slot_in,
   input  logic [pott_pkg::TIME_BITS-1:0]  now,
   output pott_pkg::slot_type              slot_out,
   output logic                            due
);
   import pott_pkg::*;

   logic                  valid_ff;
   logic [TAG_BITS-1:0]   tag_ff;
   logic [TIME_BITS-1:0]  due_ff;
   logic [TICKS_BITS-1:0] period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= slot_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         tag_ff    <= slot_in.tag;
         due_ff    <= slot_in.due;
         period_ff <= slot_in.period;
      end
   end

   assign slot_out = '{valid: valid_ff, tag: tag_ff, due: due_ff, period: period_ff};
   assign due      = valid_ff & time_due(due_ff, now);

endmodule

### hdl/periodic_oneshot_timer_table.sv
// ----------------------------------------------------------------------------
// Periodic / one-shot timer table
// Slot table kept in a ring of cells; create items fill the lowest free slot,
// tick items advance time and report every due slot in index order.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------
//  req     | req_valid req_stall req_item   | tick or create item, in
//  rsp     | rsp_valid rsp_stall rsp_item   | create ack or fired slot, out
//
//  Flow: one item at a time. The ring rotates one slot past the head cell per
//  cycle unless held as told under Stalls; a create's ack goes out after the full
//  pass over the ring.
//  Reset: synchronous, clears time, all slot valid bits and the result valid bit.
//  Stalls: a due slot at the head holds the ring until the result register
//  frees up; a stalled result is held while the next item is already accepted.
//
`include "periodic_oneshot_timer_table_assert.svh"

module periodic_oneshot_timer_table (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pott_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pott_pkg::rsp_item_type rsp_item
);
   import pott_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_ACK  = 3'b100
   } state_type;

   localparam logic [IDX_BITS-1:0] LAST_STEP = IDX_BITS'(MAX_ROUTINES - 1);

   // control and time
   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   step_ff, step_in;       // slot index at the head cell
   logic                  kind_ff, kind_in;       // request kind under work
   logic [TIME_BITS-1:0]  now_ff, now_in;

   // latched create request
   logic [TAG_BITS-1:0]   cre_tag_ff, cre_tag_in;
   logic [TIME_BITS-1:0]  cre_due_ff, cre_due_in;
   logic [TICKS_BITS-1:0] cre_period_ff, cre_period_in;
   logic                  placed_ff, placed_in;
   logic [IDX_BITS-1:0]   place_idx_ff, place_idx_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;
   logic                  rsp_load;
   logic                  out_free;

   // ring
   slot_type              ring_out [MAX_ROUTINES];
   logic [MAX_ROUTINES-1:0] due_vec;
   slot_type              wb_in;                  // head record written to the tail
   slot_type              head;
   logic                  shift;
   logic                  later_due;

   assign head     = ring_out[0];
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ROUTINES; gi++) begin : g_cell
         slot_type cell_in;
         if (gi == MAX_ROUTINES - 1) begin : g_tail
            assign cell_in = wb_in;
         end else begin : g_link
            assign cell_in = ring_out[gi+1];
         end
         pott_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (shift),
            .slot_in  (cell_in),
            .now      (now_ff),
            .slot_out (ring_out[gi]),
            .due      (due_vec[gi])
         );
      end
   endgenerate

   // any still unscanned slot due? cells 1 .. (N-1-step) hold those slots
   always_comb begin
      later_due = 1'b0;
      for (int p = 1; p < MAX_ROUTINES; p++) begin
         if ((p + int'(step_ff) < MAX_ROUTINES) && due_vec[p]) begin
            later_due = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      kind_in       = kind_ff;
      now_in        = now_ff;
      cre_tag_in    = cre_tag_ff;
      cre_due_in    = cre_due_ff;
      cre_period_in = cre_period_ff;
      placed_in     = placed_ff;
      place_idx_in  = place_idx_ff;
      shift         = 1'b0;
      wb_in         = head;
      rsp_load      = 1'b0;
      rsp_item_in   = rsp_item_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_item.req_type;
               step_in  = '0;
               state_in = ST_SCAN;
               if (req_item.req_type == REQ_CREATE) begin
                  cre_tag_in    = req_item.routine_tag;
                  cre_due_in    = add_time(now_ff, req_item.delay_ticks);
                  cre_period_in = req_item.period_ticks;
                  placed_in     = 1'b0;
               end else begin
                  now_in = now_ff + TIME_BITS'(1);
               end
            end
         end

         ST_SCAN: begin
            if (kind_ff == REQ_CREATE) begin
               shift = 1'b1;
               // first free slot seen in index order takes the new routine
               if (!head.valid && !placed_ff) begin
                  wb_in        = '{valid: 1'b1, tag: cre_tag_ff, due: cre_due_ff,
                                   period: cre_period_ff};
                  placed_in    = 1'b1;
                  place_idx_in = step_ff;
               end
            end else begin
               if (!due_vec[0]) begin
                  shift = 1'b1;
               end else if (out_free) begin
                  shift    = 1'b1;
                  rsp_load = 1'b1;
                  rsp_item_in = '{result_kind: KIND_FIRED, status: STATUS_OK,
                                  slot_index: idx_to_out(step_ff), fired_tag: head.tag,
                                  was_one_shot: (head.period == '0), last: ~later_due};
                  if (head.period == '0) begin
                     wb_in.valid = 1'b0;
                  end else begin
                     wb_in.due = add_time(now_ff, head.period);
                  end
               end
            end
            if (shift) begin
               if (step_ff == LAST_STEP) begin
                  step_in  = '0;
                  state_in = (kind_ff == REQ_CREATE) ? ST_ACK : ST_IDLE;
               end else begin
                  step_in = step_ff + IDX_BITS'(1);
               end
            end
         end

         ST_ACK: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_item_in = '{result_kind: KIND_ACK,
                               status: placed_ff ? STATUS_OK : STATUS_FULL,
                               slot_index: placed_ff ? idx_to_out(place_idx_ff) : '0,
                               fired_tag: cre_tag_ff, was_one_shot: 1'b0, last: 1'b1};
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      cre_tag_ff    <= cre_tag_in;
      cre_due_ff    <= cre_due_in;
      cre_period_ff <= cre_period_in;
      placed_ff     <= placed_in;
      place_idx_ff  <= place_idx_in;
      rsp_item_ff   <= rsp_item_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---- checks ----
   `POTT_CHECK(a_tick_advances, (req_valid && !req_stall && req_item.req_type == REQ_TICK) |=> (now_ff == $past(now_ff) + TIME_BITS'(1)), "tick did not advance time")
   `POTT_CHECK(a_idle_aligned, (state_ff == ST_IDLE) |-> (step_ff == '0), "ring not aligned while idle")
   `POTT_CHECK(a_fire_from_head, (rsp_load && rsp_item_in.result_kind == KIND_FIRED) |-> (state_ff == ST_SCAN && kind_ff == REQ_TICK && due_vec[0]), "fired result without due head slot")
   `POTT_CHECK_RST(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid), "not idle after reset")

endmodule

### verif/tb_periodic_oneshot_timer_table.sv
// ----------------------------------------------------------------------------
// Timer table testbench
// Drives tick and create items with random gaps and result stalls, predicts
// every acknowledgement and firing, and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_periodic_oneshot_timer_table;

   import pott_pkg::*;

   localparam int RANDOM_ITEMS = 140;
   localparam int DRAIN_CYCLES = 4 * MAX_ROUTINES + 20;
   // ~170 items, each with up to 16 results under drawn result stalls, plus gaps;
   // the limit leaves a wide margin over the worst case
   localparam int RUN_LIMIT    = 600000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   periodic_oneshot_timer_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state: tick counter and the slot table
   // ------------------------------------------------------------------------
   logic [TIME_BITS-1:0]  now_ticks = '0;
   bit                    tbl_live   [MAX_ROUTINES];
   logic [TAG_BITS-1:0]   tbl_tag    [MAX_ROUTINES];
   logic [TIME_BITS-1:0]  tbl_due    [MAX_ROUTINES];
   logic [TICKS_BITS-1:0] tbl_period [MAX_ROUTINES];

   req_item_type queued_requests[$];   // items not yet offered to the block
   rsp_item_type awaited_results[$];   // predicted results, oldest first

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  req_taken      = 1'b0;         // set at the edge that accepted an item
   bit  rsp_taken      = 1'b0;
   int  req_gap        = 0;
   int  rsp_hold       = 0;
   bit  req_steady     = 1'b0;         // stretch with no idling on that side
   bit  rsp_steady     = 1'b0;

   // Works out the results of one accepted item and updates the table.
   function automatic void compute_timer_results(input req_item_type it);
      rsp_item_type         fired[$];
      rsp_item_type         r;
      int                   slot;
      logic [TIME_BITS-1:0] lag;
      slot = -1;
      if (it.req_type == REQ_CREATE) begin
         // lowest free slot
         for (int i = MAX_ROUTINES - 1; i >= 0; i--) begin
            if (!tbl_live[i]) slot = i;
         end
         r = '0;
         r.result_kind = KIND_ACK;
         r.fired_tag   = it.routine_tag;
         r.last        = 1'b1;
         if (slot < 0) begin
            // table full: dropped, index reads 0
            r.status = STATUS_FULL;
         end else begin
            tbl_live[slot]   = 1'b1;
            tbl_tag[slot]    = it.routine_tag;
            tbl_due[slot]    = now_ticks + it.delay_ticks;
            tbl_period[slot] = it.period_ticks;
            r.status         = STATUS_OK;
            r.slot_index     = OUT_IDX_BITS'(slot);
         end
         awaited_results.push_back(r);
      end else begin
         now_ticks = now_ticks + 1'b1;
         for (int i = 0; i < MAX_ROUTINES; i++) begin
            if (tbl_live[i]) begin
               // due when the wrapped distance past the due time is in the lower half
               lag = now_ticks - tbl_due[i];
               if (!lag[TIME_BITS-1]) begin
                  r = '0;
                  r.result_kind  = KIND_FIRED;
                  r.status       = STATUS_OK;
                  r.slot_index   = OUT_IDX_BITS'(i);
                  r.fired_tag    = tbl_tag[i];
                  r.was_one_shot = (tbl_period[i] == '0);
                  fired.push_back(r);
                  // a re-armed slot is not looked at again in this scan
                  if (r.was_one_shot) tbl_live[i] = 1'b0;
                  else tbl_due[i] = now_ticks + tbl_period[i];
               end
            end
         end
         // a quiet tick gives nothing
         if (fired.size() > 0) begin
            r = fired.pop_back();
            r.last = 1'b1;
            fired.push_back(r);
         end
         foreach (fired[k]) awaited_results.push_back(fired[k]);
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("ERROR cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result %h", got));
      end else begin
         want = awaited_results.pop_front();
         if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind %b, want %b", got.result_kind,
                                      want.result_kind));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %b, want %b", got.status, want.status));
         if (got.slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, want %0d", got.slot_index,
                                      want.slot_index));
         if (got.fired_tag !== want.fired_tag)
            report_mismatch($sformatf("fired_tag %h, want %h", got.fired_tag,
                                      want.fired_tag));
         if (got.was_one_shot !== want.was_one_shot)
            report_mismatch($sformatf("was_one_shot %b, want %b", got.was_one_shot,
                                      want.was_one_shot));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      end
   endtask

   // Idle cycles before the next item on one side; now and then flips into or
   // out of a stretch with no idling at all.
   function automatic int draw_wait(inout bit steady);
      if ($urandom_range(0, 15) == 0) steady = !steady;
      return steady ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic req_item_type create_item(input logic [TAG_BITS-1:0]   tag,
                                                input logic [TICKS_BITS-1:0] delay,
                                                input logic [TICKS_BITS-1:0] period);
      req_item_type it;
      it.req_type     = REQ_CREATE;
      it.routine_tag  = tag;
      it.delay_ticks  = delay;
      it.period_ticks = period;
      return it;
   endfunction

   // tick with junk in the fields the block ignores
   function automatic req_item_type tick_item();
      req_item_type it;
      it.req_type     = REQ_TICK;
      it.routine_tag  = TAG_BITS'($urandom());
      it.delay_ticks  = TICKS_BITS'($urandom());
      it.period_ticks = TICKS_BITS'($urandom());
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // Sampling at the rising edge: accepted items feed the predictor, accepted
   // results are checked.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (req_valid && req_stall === 1'b0) begin
            compute_timer_results(req_item);
            req_taken = 1'b1;
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            check_result(rsp_item);
            rsp_taken = 1'b1;
         end
      end
   end

   // Request driver: holds an item until taken, then idles for the drawn gap.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap--;
            end else if (queued_requests.size() > 0) begin
               req_item  <= queued_requests.pop_front();
               req_valid <= 1'b1;
               req_gap   = draw_wait(req_steady);
            end else begin
               req_valid <= 1'b0;
            end
         end
         req_taken = 1'b0;
      end
   end

   // Result stall: after each taken result, stall for a drawn number of cycles.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_hold  = draw_wait(rsp_steady);
            rsp_taken = 1'b0;
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Run limit
   initial begin
      while (cycle_count < RUN_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int                    perm_slots;   // slots held for the rest of the run
      int                    left;
      int                    n_create;
      int                    n_tick;
      int                    roll;
      logic [TICKS_BITS-1:0] delay;
      logic [TICKS_BITS-1:0] period;

      foreach (tbl_live[i]) tbl_live[i] = 1'b0;

      // Directed part.
      // one-shot with zero delay fires on the next tick; then a quiet tick
      queued_requests.push_back(create_item(16'hFFFF, '0, '0));
      queued_requests.push_back(tick_item());
      queued_requests.push_back(tick_item());
      // all-ones delay and period: due at once, re-armed one tick behind now,
      // so it fires on every tick
      queued_requests.push_back(create_item(16'h0000, '1, '1));
      queued_requests.push_back(create_item(16'hA5A5, 32'd2, '0));
      // half-range edge: one just short of counting as due, one just past it
      queued_requests.push_back(create_item(16'h5A5A, 32'h8000_0001, '0));
      queued_requests.push_back(create_item(16'h1234, 32'h8000_0002, '0));
      queued_requests.push_back(create_item(16'h0F0F, 32'd1, 32'd1));
      queued_requests.push_back(create_item(16'hF0F0, 32'd3, 32'd3));
      repeat (3) queued_requests.push_back(tick_item());
      // four slots stay taken; fill the other twelve and one more hits full
      repeat (MAX_ROUTINES - 3) queued_requests.push_back(create_item(TAG_BITS'($urandom()),
                                                                      '0, '0));
      // this tick fires nearly the whole table
      queued_requests.push_back(tick_item());
      perm_slots = 4;

      // Random part: bursts of creates followed by runs of ticks. Periodic and
      // never-due slots are never freed, so they are rationed to keep slots
      // turning over.
      left = RANDOM_ITEMS;
      while (left > 0) begin
         n_create = $urandom_range(0, 4);
         n_tick   = $urandom_range(0, 10);
         repeat (n_create) begin
            roll   = $urandom_range(0, 99);
            period = '0;
            if (roll < 60) delay = $urandom_range(0, 12);
            else if (roll < 85) delay = {1'b1, 31'($urandom())};  // wraps: due next tick
            else if (roll < 95) delay = '1;
            else delay = '0;
            if (perm_slots < 10 && $urandom_range(0, 5) == 0) begin
               period = ($urandom_range(0, 3) == 0) ? TICKS_BITS'($urandom())
                                                    : TICKS_BITS'($urandom_range(1, 8));
               perm_slots++;
            end
            queued_requests.push_back(create_item(TAG_BITS'($urandom()), delay, period));
            left--;
         end
         repeat (n_tick) begin
            queued_requests.push_back(tick_item());
            left--;
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (queued_requests.size() != 0 || req_valid) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      // stray results after the last one would show up here
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (awaited_results.size() != 0)
         report_mismatch($sformatf("%0d results never came", awaited_results.size()));
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
